// File: design/typed_data_stack_engine_macros.svh
`ifndef TYPED_DATA_STACK_ENGINE_MACROS_SVH
`define TYPED_DATA_STACK_ENGINE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TDSE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define TDSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tdse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdse_pkg;

    localparam int unsigned STACK_DEPTH = 1024;
    localparam int unsigned AW          = $clog2(STACK_DEPTH);
    localparam int unsigned SP_W        = AW + 1;
    localparam int unsigned KIND_W      = 4;
    localparam int unsigned VAL_W       = 64;
    localparam int unsigned FUNC_W      = 5;
    localparam int unsigned STAT_W      = 3;

    localparam logic [KIND_W-1:0] KIND_INT  = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_MARK = KIND_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH     = 5'd0,
        F_POP      = 5'd1,
        F_DUP      = 5'd2,
        F_QDUP     = 5'd3,
        F_NDUP     = 5'd4,
        F_DUPN     = 5'd5,
        F_LDUP     = 5'd6,
        F_NIP      = 5'd7,
        F_TUCK     = 5'd8,
        F_SWAP     = 5'd9,
        F_OVER     = 5'd10,
        F_PICK     = 5'd11,
        F_PUT      = 5'd12,
        F_ROT      = 5'd13,
        F_POPN     = 5'd14,
        F_ROTATE   = 5'd15,
        F_REVERSE  = 5'd16,
        F_LREVERSE = 5'd17,
        F_DEPTH    = 5'd18,
        F_MARK     = 5'd19,
        F_FINDMARK = 5'd20
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_TYPE  = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        WS_RDATA,
        WS_TA,
        WS_TB,
        WS_TS,
        WS_PUSH,
        WS_INT,
        WS_MARK
    } t_wsel;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [KIND_W-1:0]       push_kind;
        logic signed [VAL_W-1:0] push_value;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [KIND_W-1:0]       top_kind;
        logic signed [VAL_W-1:0] top_value;
        logic [SP_W-1:0]         stack_count;
    } t_result;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
    } t_elem;

    typedef struct packed {
        logic            rd_en;
        logic [AW-1:0]   rd_addr;
        logic            wr_en;
        logic [AW-1:0]   wr_addr;
        t_wsel           wr_sel;
        logic [SP_W-1:0] wr_int;
        logic            cap_a;
        logic            cap_b;
        logic            cap_s;
        logic            ld_push;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_mark;
        logic              val_zero;
        logic              cnt_neg;
        logic              cnt_big;
        logic [SP_W-1:0]   cnt_mag;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: design/tdse_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module tdse_dpath (
    input  logic               i_clk,
    input  tdse_pkg::t_item    i_item,
    input  tdse_pkg::t_dp_cmd  i_cmd,
    output tdse_pkg::t_dp_stat o_stat,
    output tdse_pkg::t_elem    o_rdata
);

    tdse_pkg::t_elem r_mem [tdse_pkg::STACK_DEPTH];
    tdse_pkg::t_elem r_rdata;
    tdse_pkg::t_elem r_ta;
    tdse_pkg::t_elem r_tb;
    tdse_pkg::t_elem r_ts;
    tdse_pkg::t_elem r_push;
    tdse_pkg::t_elem w_wdata;
    logic [tdse_pkg::VAL_W-1:0] w_mag;

    always_comb begin
        w_wdata = r_rdata;
        case (i_cmd.wr_sel)
            tdse_pkg::WS_RDATA: w_wdata = r_rdata;
            tdse_pkg::WS_TA:    w_wdata = r_ta;
            tdse_pkg::WS_TB:    w_wdata = r_tb;
            tdse_pkg::WS_TS:    w_wdata = r_ts;
            tdse_pkg::WS_PUSH:  w_wdata = r_push;
            tdse_pkg::WS_INT: begin
                w_wdata.kind  = tdse_pkg::KIND_INT;
                w_wdata.value = {{(tdse_pkg::VAL_W - tdse_pkg::SP_W){1'b0}}, i_cmd.wr_int};
            end
            tdse_pkg::WS_MARK: begin
                w_wdata.kind  = tdse_pkg::KIND_MARK;
                w_wdata.value = '0;
            end
            default: w_wdata = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_cmd.rd_addr];
        end
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= w_wdata;
        end
        if (i_cmd.cap_a) begin
            r_ta <= r_rdata;
        end
        if (i_cmd.cap_b) begin
            r_tb <= r_rdata;
        end
        if (i_cmd.cap_s) begin
            r_ts <= r_rdata;
        end
        if (i_cmd.ld_push) begin
            r_push.kind  <= i_item.push_kind;
            r_push.value <= i_item.push_value;
        end
    end

    // magnitude of the count for range checks
    assign w_mag = r_rdata.value[tdse_pkg::VAL_W-1] ? (~r_rdata.value + 1'b1) : r_rdata.value;

    assign o_stat.kind     = r_rdata.kind;
    assign o_stat.is_mark  = (r_rdata.kind == tdse_pkg::KIND_MARK);
    assign o_stat.val_zero = (r_rdata.value == '0);
    assign o_stat.cnt_neg  = r_rdata.value[tdse_pkg::VAL_W-1];
    assign o_stat.cnt_big  = |w_mag[tdse_pkg::VAL_W-1:tdse_pkg::SP_W];
    assign o_stat.cnt_mag  = w_mag[tdse_pkg::SP_W-1:0];
    assign o_rdata         = r_rdata;

endmodule

`default_nettype wire

// File: design/tdse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "typed_data_stack_engine_macros.svh"

module tdse_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tdse_pkg::FUNC_W-1:0]   i_func,
    input  tdse_pkg::t_dp_stat            i_stat,
    output tdse_pkg::t_dp_cmd             o_cmd,
    output logic                          o_done,
    output logic [tdse_pkg::STAT_W-1:0]   o_status,
    output logic [tdse_pkg::SP_W-1:0]     o_sp
);

    localparam int unsigned AW   = tdse_pkg::AW;
    localparam int unsigned SP_W = tdse_pkg::SP_W;
    localparam int unsigned XW   = tdse_pkg::SP_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CNT_RD, S_PLAN, S_FM_RD, S_FM_CHK, S_SV_RD, S_SV_CAP,
        S_CP_RD, S_CP_WR, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_FIN,
        S_TOP_RD, S_OUT
    } t_state;

    typedef enum logic [1:0] {STEP_HOLD, STEP_UP, STEP_DOWN} t_step;
    typedef enum logic [1:0] {LP_NONE, LP_COPY, LP_SWAP} t_loop;

    t_state            r_state,    n_state;
    tdse_pkg::t_func   r_func,     n_func;
    logic [SP_W-1:0]   r_sp,       n_sp;
    logic [SP_W-1:0]   r_new_sp,   n_new_sp;
    tdse_pkg::t_status r_status,   n_status;
    logic [AW-1:0]     r_src,      n_src;
    logic [AW-1:0]     r_dst,      n_dst;
    t_step             r_src_step, n_src_step;
    t_step             r_dst_step, n_dst_step;
    logic [SP_W-1:0]   r_cnt,      n_cnt;
    t_loop             r_loop,     n_loop;
    logic              r_save_en,  n_save_en;
    logic [AW-1:0]     r_save_addr, n_save_addr;
    logic              r_fin_en,   n_fin_en;
    logic [AW-1:0]     r_fin_addr, n_fin_addr;
    tdse_pkg::t_wsel   r_fin_sel,  n_fin_sel;
    logic [SP_W-1:0]   r_fin_int,  n_fin_int;
    logic [AW-1:0]     r_idx,      n_idx;

    function automatic t_state after_setup(input t_loop lp, input logic [SP_W-1:0] cnt,
                                           input logic fin);
        t_state s;
        if (lp == LP_COPY && cnt != '0) begin
            s = S_CP_RD;
        end else if (lp == LP_SWAP && cnt != '0) begin
            s = S_SW_RA;
        end else if (fin) begin
            s = S_FIN;
        end else begin
            s = S_TOP_RD;
        end
        return s;
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [XW-1:0] x);
        return x[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] step_addr(input logic [AW-1:0] a, input t_step s);
        logic [AW-1:0] r;
        case (s)
            STEP_UP:   r = a + 1'b1;
            STEP_DOWN: r = a - 1'b1;
            default:   r = a;
        endcase
        return r;
    endfunction

    always_comb begin
        logic [XW-1:0]     spx;
        logic [XW-1:0]     mx;
        logic [XW-1:0]     nx;
        logic [XW-1:0]     dx;
        logic [XW-1:0]     cx;
        logic              neg;
        logic              big;
        logic              pos;
        tdse_pkg::t_status cerr;

        n_state     = r_state;
        n_func      = r_func;
        n_sp        = r_sp;
        n_new_sp    = r_new_sp;
        n_status    = r_status;
        n_src       = r_src;
        n_dst       = r_dst;
        n_src_step  = r_src_step;
        n_dst_step  = r_dst_step;
        n_cnt       = r_cnt;
        n_loop      = r_loop;
        n_save_en   = r_save_en;
        n_save_addr = r_save_addr;
        n_fin_en    = r_fin_en;
        n_fin_addr  = r_fin_addr;
        n_fin_sel   = r_fin_sel;
        n_fin_int   = r_fin_int;
        n_idx       = r_idx;

        spx = XW'(r_sp);
        mx  = spx - 1'b1;
        nx  = XW'(i_stat.cnt_mag);
        dx  = XW'(tdse_pkg::STACK_DEPTH);
        cx  = spx - XW'(r_idx) - 1'b1;
        neg = i_stat.cnt_neg;
        big = i_stat.cnt_big;
        pos = !neg && !i_stat.val_zero;
        if (spx == '0) begin
            cerr = tdse_pkg::ST_UNDER;
        end else if (i_stat.kind != tdse_pkg::KIND_INT) begin
            cerr = tdse_pkg::ST_TYPE;
        end else begin
            cerr = tdse_pkg::ST_OK;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func  = tdse_pkg::t_func'(i_func);
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_RD: n_state = S_PLAN;
            S_PLAN: begin
                n_status   = tdse_pkg::ST_OK;
                n_new_sp   = r_sp;
                n_loop     = LP_NONE;
                n_cnt      = '0;
                n_save_en  = 1'b0;
                n_fin_en   = 1'b0;
                n_fin_sel  = tdse_pkg::WS_RDATA;
                n_fin_int  = '0;
                n_src_step = STEP_UP;
                n_dst_step = STEP_UP;
                case (r_func)
                    tdse_pkg::F_PUSH: begin
                        if (spx >= dx) begin
                            n_status = tdse_pkg::ST_OVER;
                        end else begin
                            n_fin_en = 1'b1; n_fin_addr = to_addr(spx);
                            n_fin_sel = tdse_pkg::WS_PUSH; n_new_sp = SP_W'(spx + 1'b1);
                        end
                    end
                    tdse_pkg::F_POP: begin
                        if (spx == '0) n_status = tdse_pkg::ST_UNDER;
                        else n_new_sp = SP_W'(mx);
                    end
                    tdse_pkg::F_DUP, tdse_pkg::F_QDUP: begin
                        if (spx == '0) begin
                            n_status = tdse_pkg::ST_UNDER;
                        end else if (r_func == tdse_pkg::F_QDUP && i_stat.val_zero) begin
                            n_new_sp = r_sp;
                        end else if (spx >= dx) begin
                            n_status = tdse_pkg::ST_OVER;
                        end else begin
                            n_fin_en = 1'b1; n_fin_addr = to_addr(spx);
                            n_new_sp = SP_W'(spx + 1'b1);
                        end
                    end
                    tdse_pkg::F_NDUP: begin
                        if (cerr != tdse_pkg::ST_OK) begin
                            n_status = cerr;
                        end else if (mx == '0) begin
                            n_status = tdse_pkg::ST_UNDER;
                        end else if (pos && (big || nx > dx - mx)) begin
                            n_status = tdse_pkg::ST_OVER;
                        end else if (pos) begin
                            n_loop = LP_COPY; n_src = to_addr(mx - 1'b1); n_src_step = STEP_HOLD;
                            n_dst = to_addr(mx); n_cnt = SP_W'(nx);
                            n_new_sp = SP_W'(mx + nx);
                        end else begin
                            n_new_sp = SP_W'(mx);
                        end
                    end
                    tdse_pkg::F_DUPN: begin
                        if (cerr != tdse_pkg::ST_OK) n_status = cerr;
                        else if (neg) n_status = tdse_pkg::ST_RANGE;
                        else if (big || nx > mx) n_status = tdse_pkg::ST_UNDER;
                        else if (nx > dx - mx) n_status = tdse_pkg::ST_OVER;
                        else begin
                            n_loop = LP_COPY; n_src = to_addr(mx - nx); n_dst = to_addr(mx);
                            n_cnt = SP_W'(nx); n_new_sp = SP_W'(mx + nx);
                        end
                    end
                    tdse_pkg::F_LDUP: begin
                        if (cerr != tdse_pkg::ST_OK) n_status = cerr;
                        else if (neg) n_status = tdse_pkg::ST_RANGE;
                        else if (big || nx >= spx) n_status = tdse_pkg::ST_UNDER;
                        else if (nx + 1'b1 > dx - spx) n_status = tdse_pkg::ST_OVER;
                        else begin
                            n_loop = LP_COPY; n_src = to_addr(spx - nx - 1'b1);
                            n_dst = to_addr(spx); n_cnt = SP_W'(nx + 1'b1);
                            n_new_sp = SP_W'(spx + nx + 1'b1);
                        end
                    end
                    tdse_pkg::F_NIP: begin
                        if (spx < XW'(2)) n_status = tdse_pkg::ST_UNDER;
                        else begin
                            n_fin_en = 1'b1; n_fin_addr = to_addr(spx - XW'(2));
                            n_new_sp = SP_W'(mx);
                        end
                    end
                    tdse_pkg::F_TUCK: begin
                        if (spx < XW'(2)) n_status = tdse_pkg::ST_UNDER;
                        else if (spx >= dx) n_status = tdse_pkg::ST_OVER;
                        else begin
                            n_loop = LP_SWAP; n_src = to_addr(spx - XW'(2)); n_dst = to_addr(mx);
                            n_cnt = SP_W'(1); n_fin_en = 1'b1; n_fin_addr = to_addr(spx);
                            n_fin_sel = tdse_pkg::WS_TB; n_new_sp = SP_W'(spx + 1'b1);
                        end
                    end
                    tdse_pkg::F_SWAP: begin
                        if (spx < XW'(2)) n_status = tdse_pkg::ST_UNDER;
                        else begin
                            n_loop = LP_SWAP; n_src = to_addr(spx - XW'(2)); n_dst = to_addr(mx);
                            n_cnt = SP_W'(1);
                        end
                    end
                    tdse_pkg::F_OVER: begin
                        if (spx < XW'(2)) n_status = tdse_pkg::ST_UNDER;
                        else if (spx >= dx) n_status = tdse_pkg::ST_OVER;
                        else begin
                            n_loop = LP_COPY; n_src = to_addr(spx - XW'(2)); n_dst = to_addr(spx);
                            n_cnt = SP_W'(1); n_new_sp = SP_W'(spx + 1'b1);
                        end
                    end
                    tdse_pkg::F_PICK: begin
                        if (cerr != tdse_pkg::ST_OK) n_status = cerr;
                        else if (!pos) n_status = tdse_pkg::ST_RANGE;
                        else if (big || nx > mx) n_status = tdse_pkg::ST_UNDER;
                        else begin
                            n_loop = LP_COPY; n_src = to_addr(mx - nx); n_dst = to_addr(mx);
                            n_cnt = SP_W'(1);
                        end
                    end
                    tdse_pkg::F_PUT: begin
                        if (spx < XW'(2)) n_status = tdse_pkg::ST_UNDER;
                        else if (cerr != tdse_pkg::ST_OK) n_status = cerr;
                        else if (!pos) n_status = tdse_pkg::ST_RANGE;
                        else if (big || nx > spx - XW'(2)) n_status = tdse_pkg::ST_UNDER;
                        else begin
                            n_loop = LP_COPY; n_src = to_addr(spx - XW'(2));
                            n_dst = to_addr(spx - XW'(2) - nx); n_cnt = SP_W'(1);
                            n_new_sp = SP_W'(spx - XW'(2));
                        end
                    end
                    tdse_pkg::F_ROT: begin
                        if (spx < XW'(3)) n_status = tdse_pkg::ST_UNDER;
                        else begin
                            n_loop = LP_SWAP; n_src = to_addr(spx - XW'(3));
                            n_dst = to_addr(spx - XW'(2)); n_cnt = SP_W'(2);
                        end
                    end
                    tdse_pkg::F_POPN: begin
                        if (cerr != tdse_pkg::ST_OK) n_status = cerr;
                        else if (neg || big || nx >= dx) n_status = tdse_pkg::ST_RANGE;
                        else if (nx > mx) n_status = tdse_pkg::ST_UNDER;
                        else n_new_sp = SP_W'(mx - nx);
                    end
                    tdse_pkg::F_ROTATE: begin
                        if (cerr != tdse_pkg::ST_OK) n_status = cerr;
                        else if (big || nx > mx) n_status = tdse_pkg::ST_UNDER;
                        else begin
                            n_new_sp = SP_W'(mx);
                            if (pos) begin
                                n_save_en = 1'b1; n_save_addr = to_addr(mx - nx);
                                n_loop = LP_COPY; n_src = to_addr(mx - nx + 1'b1);
                                n_dst = to_addr(mx - nx); n_cnt = SP_W'(nx - 1'b1);
                                n_fin_en = 1'b1; n_fin_addr = to_addr(mx - 1'b1);
                                n_fin_sel = tdse_pkg::WS_TS;
                            end else if (neg) begin
                                n_save_en = 1'b1; n_save_addr = to_addr(mx - 1'b1);
                                n_loop = LP_COPY; n_src = to_addr(mx - XW'(2));
                                n_dst = to_addr(mx - 1'b1); n_src_step = STEP_DOWN;
                                n_dst_step = STEP_DOWN; n_cnt = SP_W'(nx - 1'b1);
                                n_fin_en = 1'b1; n_fin_addr = to_addr(mx - nx);
                                n_fin_sel = tdse_pkg::WS_TS;
                            end
                        end
                    end
                    tdse_pkg::F_REVERSE, tdse_pkg::F_LREVERSE: begin
                        if (cerr != tdse_pkg::ST_OK) n_status = cerr;
                        else if (neg) n_status = tdse_pkg::ST_RANGE;
                        else if (big || nx > mx) n_status = tdse_pkg::ST_UNDER;
                        else begin
                            n_loop = LP_SWAP; n_src = to_addr(mx - nx);
                            n_dst = to_addr(mx - 1'b1); n_dst_step = STEP_DOWN;
                            n_cnt = SP_W'(nx >> 1);
                            if (r_func == tdse_pkg::F_LREVERSE) begin
                                n_fin_en = 1'b1; n_fin_addr = to_addr(mx);
                                n_fin_sel = tdse_pkg::WS_INT; n_fin_int = SP_W'(nx);
                            end else begin
                                n_new_sp = SP_W'(mx);
                            end
                        end
                    end
                    tdse_pkg::F_DEPTH, tdse_pkg::F_MARK: begin
                        if (spx >= dx) n_status = tdse_pkg::ST_OVER;
                        else begin
                            n_fin_en = 1'b1; n_fin_addr = to_addr(spx); n_fin_int = r_sp;
                            n_new_sp = SP_W'(spx + 1'b1);
                            if (r_func == tdse_pkg::F_DEPTH) n_fin_sel = tdse_pkg::WS_INT;
                            else n_fin_sel = tdse_pkg::WS_MARK;
                        end
                    end
                    tdse_pkg::F_FINDMARK: begin
                        if (spx == '0) n_status = tdse_pkg::ST_RANGE;
                        else n_idx = to_addr(mx);
                    end
                    default: n_new_sp = r_sp;
                endcase
                if (n_status != tdse_pkg::ST_OK) begin
                    n_new_sp = r_sp;
                    n_state  = S_TOP_RD;
                end else if (r_func == tdse_pkg::F_FINDMARK) begin
                    n_state = S_FM_RD;
                end else if (n_save_en) begin
                    n_state = S_SV_RD;
                end else begin
                    n_state = after_setup(n_loop, n_cnt, n_fin_en);
                end
            end
            S_FM_RD: n_state = S_FM_CHK;
            S_FM_CHK: begin
                if (i_stat.is_mark) begin
                    n_loop = LP_COPY; n_src = r_idx + 1'b1; n_dst = r_idx;
                    n_src_step = STEP_UP; n_dst_step = STEP_UP; n_cnt = SP_W'(cx);
                    n_fin_en = 1'b1; n_fin_addr = to_addr(mx);
                    n_fin_sel = tdse_pkg::WS_INT; n_fin_int = SP_W'(cx);
                    n_state = after_setup(LP_COPY, SP_W'(cx), 1'b1);
                end else if (r_idx == '0) begin
                    n_status = tdse_pkg::ST_RANGE;
                    n_state  = S_TOP_RD;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_FM_RD;
                end
            end
            S_SV_RD:  n_state = S_SV_CAP;
            S_SV_CAP: n_state = after_setup(r_loop, r_cnt, r_fin_en);
            S_CP_RD:  n_state = S_CP_WR;
            S_CP_WR, S_SW_WB: begin
                n_src = step_addr(r_src, r_src_step);
                n_dst = step_addr(r_dst, r_dst_step);
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == SP_W'(1)) n_state = after_setup(LP_NONE, '0, r_fin_en);
                else if (r_state == S_CP_WR) n_state = S_CP_RD;
                else n_state = S_SW_RA;
            end
            S_SW_RA:  n_state = S_SW_RB;
            S_SW_RB:  n_state = S_SW_WA;
            S_SW_WA:  n_state = S_SW_WB;
            S_FIN:    n_state = S_TOP_RD;
            S_TOP_RD: begin
                n_sp    = r_new_sp;
                n_state = S_OUT;
            end
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.wr_sel  = tdse_pkg::WS_RDATA;
        case (r_state)
            S_IDLE:   o_cmd.ld_push = start;
            S_CNT_RD: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_addr = to_addr(XW'(r_sp) - 1'b1);
            end
            S_FM_RD: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_addr = r_idx;
            end
            S_SV_RD: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_addr = r_save_addr;
            end
            S_SV_CAP: o_cmd.cap_s = 1'b1;
            S_CP_RD, S_SW_RA: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_addr = r_src;
            end
            S_CP_WR: begin
                o_cmd.wr_en = 1'b1; o_cmd.wr_addr = r_dst;
            end
            S_SW_RB: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_addr = r_dst; o_cmd.cap_a = 1'b1;
            end
            S_SW_WA: begin
                o_cmd.wr_en = 1'b1; o_cmd.wr_addr = r_src; o_cmd.cap_b = 1'b1;
            end
            S_SW_WB: begin
                o_cmd.wr_en = 1'b1; o_cmd.wr_addr = r_dst; o_cmd.wr_sel = tdse_pkg::WS_TA;
            end
            S_FIN: begin
                o_cmd.wr_en  = 1'b1; o_cmd.wr_addr = r_fin_addr;
                o_cmd.wr_sel = r_fin_sel; o_cmd.wr_int = r_fin_int;
            end
            S_TOP_RD: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_addr = to_addr(XW'(r_new_sp) - 1'b1);
            end
            default: o_cmd.ld_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_new_sp <= '0;
            r_status <= tdse_pkg::ST_OK;
            r_loop   <= LP_NONE;
            r_save_en <= 1'b0;
            r_fin_en <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_new_sp <= n_new_sp;
            r_status <= n_status;
            r_loop   <= n_loop;
            r_save_en <= n_save_en;
            r_fin_en <= n_fin_en;
            r_cnt    <= n_cnt;
        end
        r_func      <= n_func;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_src_step  <= n_src_step;
        r_dst_step  <= n_dst_step;
        r_save_addr <= n_save_addr;
        r_fin_addr  <= n_fin_addr;
        r_fin_sel   <= n_fin_sel;
        r_fin_int   <= n_fin_int;
        r_idx       <= n_idx;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_sp     = r_sp;

    `TDSE_ASSERT_NEXT(a_done_one_cycle, o_done, !o_done, "result strobe longer than one cycle")
    `TDSE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `TDSE_ASSERT_IMPL(a_sp_bound, 1'b1, r_sp <= tdse_pkg::STACK_DEPTH, "stack pointer past depth")
    `TDSE_ASSERT_IMPL(a_loop_cnt, r_state == S_CP_WR || r_state == S_SW_WB, r_cnt != '0, "loop step with zero count")

endmodule

`default_nettype wire

// File: design/typed_data_stack_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Typed data stack: runs one stack word per input beat.
// Input: i_item (func, push_kind, push_value) is taken at a clock edge where
// start is high and busy is low. busy stays high until the result is shown.
// Output: o_result (status, top_kind, top_value, stack_count) is valid for
// exactly one cycle while o_done is high; the receiver cannot stall it.
// Each word reads the count slot, plans, and reads the new top before o_done.
// Words that touch no element (pop, popn, errors, unknown words, false ?dup,
// zero-length loops) do nothing more; single writes (push, dup, nip, depth,
// mark) add one write; each copied element (over, pick, put, ndup, dupn, ldup,
// rotate, findmark) adds a read and a write; each swapped pair (swap, tuck, rot,
// reverse, lreverse) adds two reads and two writes; tuck, lreverse, rotate and
// findmark end with a closing write, rotate first reads its saved element and
// findmark reads each element it scans, all through one element memory.
// A new beat can be taken the cycle after o_done.
// Reset (synchronous, active low) empties the stack; element memory is not
// cleared and needs no clearing pass.

module typed_data_stack_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tdse_pkg::t_item   i_item,
    output logic              o_done,
    output tdse_pkg::t_result o_result
);

    tdse_pkg::t_dp_cmd               w_cmd;
    tdse_pkg::t_dp_stat              w_stat;
    tdse_pkg::t_elem                 w_rdata;
    logic [tdse_pkg::STAT_W-1:0]     w_status;
    logic [tdse_pkg::SP_W-1:0]       w_sp;

    tdse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_func   (i_item.func),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_done   (o_done),
        .o_status (w_status),
        .o_sp     (w_sp)
    );

    tdse_dpath u_dpath (
        .i_clk   (i_clk),
        .i_item  (i_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_rdata (w_rdata)
    );

    // empty stack reads as zero
    assign o_result.status      = w_status;
    assign o_result.top_kind    = (w_sp == '0) ? '0 : w_rdata.kind;
    assign o_result.top_value   = (w_sp == '0) ? '0 : w_rdata.value;
    assign o_result.stack_count = w_sp;

endmodule

`default_nettype wire

// File: dv/tdse_checker.sv
`timescale 1ns / 1ps

module tdse_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  tdse_pkg::t_item   i_item,
    input  logic              o_done,
    input  tdse_pkg::t_result o_result,
    output int                errors,
    output int                pending,
    output int                beats_in,
    output int                beats_out,
    output int                fault_beats
);

    logic [tdse_pkg::KIND_W-1:0] stack_kind [tdse_pkg::STACK_DEPTH];
    logic [tdse_pkg::VAL_W-1:0]  stack_val  [tdse_pkg::STACK_DEPTH];
    int                          stack_ptr;
    tdse_pkg::t_result           expected_results [$];

    initial begin
        errors      = 0;
        beats_in    = 0;
        beats_out   = 0;
        fault_beats = 0;
        stack_ptr   = 0;
    end

    assign pending = expected_results.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t tdse_checker: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void copy_el(input int dst, input int src);
        stack_kind[dst] = stack_kind[src];
        stack_val[dst]  = stack_val[src];
    endfunction

    function automatic void set_el(input int dst, input logic [tdse_pkg::KIND_W-1:0] k,
                                   input logic [tdse_pkg::VAL_W-1:0] v);
        stack_kind[dst] = k;
        stack_val[dst]  = v;
    endfunction

    function automatic void swap_el(input int a, input int b);
        logic [tdse_pkg::KIND_W-1:0] k;
        logic [tdse_pkg::VAL_W-1:0]  v;
        k = stack_kind[a];
        v = stack_val[a];
        copy_el(a, b);
        set_el(b, k, v);
    endfunction

    // count on top of stack: status, or ok with n filled
    function automatic tdse_pkg::t_status take_count(output longint n);
        n = 0;
        if (stack_ptr == 0) return tdse_pkg::ST_UNDER;
        if (stack_kind[stack_ptr-1] != tdse_pkg::KIND_INT) return tdse_pkg::ST_TYPE;
        n = $signed(stack_val[stack_ptr-1]);
        return tdse_pkg::ST_OK;
    endfunction

    function automatic tdse_pkg::t_status exec_word(input logic [tdse_pkg::FUNC_W-1:0] f,
                                                    input logic [tdse_pkg::KIND_W-1:0] pk,
                                                    input logic [tdse_pkg::VAL_W-1:0] pv);
        int                          sp;
        int                          m;
        int                          c;
        int                          b;
        longint                      n;
        tdse_pkg::t_status           st;
        logic [tdse_pkg::KIND_W-1:0] k;
        logic [tdse_pkg::VAL_W-1:0]  v;
        sp = stack_ptr;
        m  = sp - 1;
        n  = 0;
        case (f)
            tdse_pkg::F_PUSH: begin
                if (sp >= tdse_pkg::STACK_DEPTH) return tdse_pkg::ST_OVER;
                set_el(sp, pk, pv);
                stack_ptr = sp + 1;
            end
            tdse_pkg::F_POP: begin
                if (sp < 1) return tdse_pkg::ST_UNDER;
                stack_ptr = m;
            end
            tdse_pkg::F_DUP, tdse_pkg::F_QDUP: begin
                if (sp < 1) return tdse_pkg::ST_UNDER;
                if (f == tdse_pkg::F_QDUP && stack_val[m] == 0) return tdse_pkg::ST_OK;
                if (sp >= tdse_pkg::STACK_DEPTH) return tdse_pkg::ST_OVER;
                copy_el(sp, m);
                stack_ptr = sp + 1;
            end
            tdse_pkg::F_NDUP: begin
                st = take_count(n);
                if (st != tdse_pkg::ST_OK) return st;
                if (m < 1) return tdse_pkg::ST_UNDER;
                if (n > 0 && n > longint'(tdse_pkg::STACK_DEPTH - m)) return tdse_pkg::ST_OVER;
                for (int i = 0; i < n; i++) copy_el(m + i, m - 1);
                stack_ptr = m + (n > 0 ? int'(n) : 0);
            end
            tdse_pkg::F_DUPN: begin
                st = take_count(n);
                if (st != tdse_pkg::ST_OK) return st;
                if (n < 0) return tdse_pkg::ST_RANGE;
                if (n > m) return tdse_pkg::ST_UNDER;
                if (n > longint'(tdse_pkg::STACK_DEPTH - m)) return tdse_pkg::ST_OVER;
                c = int'(n);
                for (int i = 0; i < c; i++) copy_el(m + i, m - c + i);
                stack_ptr = m + c;
            end
            tdse_pkg::F_LDUP: begin
                st = take_count(n);
                if (st != tdse_pkg::ST_OK) return st;
                if (n < 0) return tdse_pkg::ST_RANGE;
                if (n >= sp) return tdse_pkg::ST_UNDER;
                if (n + 1 > longint'(tdse_pkg::STACK_DEPTH - sp)) return tdse_pkg::ST_OVER;
                c = int'(n) + 1;
                for (int i = 0; i < c; i++) copy_el(sp + i, sp - c + i);
                stack_ptr = sp + c;
            end
            tdse_pkg::F_NIP: begin
                if (sp < 2) return tdse_pkg::ST_UNDER;
                copy_el(sp - 2, m);
                stack_ptr = m;
            end
            tdse_pkg::F_TUCK: begin
                if (sp < 2) return tdse_pkg::ST_UNDER;
                if (sp >= tdse_pkg::STACK_DEPTH) return tdse_pkg::ST_OVER;
                swap_el(sp - 2, m);
                copy_el(sp, sp - 2);
                stack_ptr = sp + 1;
            end
            tdse_pkg::F_SWAP: begin
                if (sp < 2) return tdse_pkg::ST_UNDER;
                swap_el(sp - 2, m);
            end
            tdse_pkg::F_OVER: begin
                if (sp < 2) return tdse_pkg::ST_UNDER;
                if (sp >= tdse_pkg::STACK_DEPTH) return tdse_pkg::ST_OVER;
                copy_el(sp, sp - 2);
                stack_ptr = sp + 1;
            end
            tdse_pkg::F_PICK: begin
                st = take_count(n);
                if (st != tdse_pkg::ST_OK) return st;
                if (n <= 0) return tdse_pkg::ST_RANGE;
                if (n > m) return tdse_pkg::ST_UNDER;
                copy_el(m, m - int'(n));
            end
            tdse_pkg::F_PUT: begin
                if (sp < 2) return tdse_pkg::ST_UNDER;
                st = take_count(n);
                if (st != tdse_pkg::ST_OK) return st;
                if (n <= 0) return tdse_pkg::ST_RANGE;
                if (n > sp - 2) return tdse_pkg::ST_UNDER;
                copy_el(sp - 2 - int'(n), sp - 2);
                stack_ptr = sp - 2;
            end
            tdse_pkg::F_ROT: begin
                if (sp < 3) return tdse_pkg::ST_UNDER;
                k = stack_kind[sp-3];
                v = stack_val[sp-3];
                copy_el(sp - 3, sp - 2);
                copy_el(sp - 2, m);
                set_el(m, k, v);
            end
            tdse_pkg::F_POPN: begin
                st = take_count(n);
                if (st != tdse_pkg::ST_OK) return st;
                if (n < 0 || n >= tdse_pkg::STACK_DEPTH) return tdse_pkg::ST_RANGE;
                if (n > m) return tdse_pkg::ST_UNDER;
                stack_ptr = m - int'(n);
            end
            tdse_pkg::F_ROTATE: begin
                st = take_count(n);
                if (st != tdse_pkg::ST_OK) return st;
                if (n > m || n < -m) return tdse_pkg::ST_UNDER;
                if (n > 0) begin
                    c = int'(n);
                    k = stack_kind[m-c];
                    v = stack_val[m-c];
                    for (int i = m - c; i + 1 < m; i++) copy_el(i, i + 1);
                    set_el(m - 1, k, v);
                end else if (n < 0) begin
                    c = int'(-n);
                    k = stack_kind[m-1];
                    v = stack_val[m-1];
                    for (int i = m - 1; i > m - c; i--) copy_el(i, i - 1);
                    set_el(m - c, k, v);
                end
                stack_ptr = m;
            end
            tdse_pkg::F_REVERSE, tdse_pkg::F_LREVERSE: begin
                st = take_count(n);
                if (st != tdse_pkg::ST_OK) return st;
                if (n < 0) return tdse_pkg::ST_RANGE;
                if (n > m) return tdse_pkg::ST_UNDER;
                c = int'(n);
                for (int i = 0; i < c / 2; i++) swap_el(m - c + i, m - 1 - i);
                if (f == tdse_pkg::F_LREVERSE)
                    set_el(m, tdse_pkg::KIND_INT, tdse_pkg::VAL_W'(n));
                else stack_ptr = m;
            end
            tdse_pkg::F_DEPTH, tdse_pkg::F_MARK: begin
                if (sp >= tdse_pkg::STACK_DEPTH) return tdse_pkg::ST_OVER;
                if (f == tdse_pkg::F_DEPTH) set_el(sp, tdse_pkg::KIND_INT, tdse_pkg::VAL_W'(sp));
                else set_el(sp, tdse_pkg::KIND_MARK, '0);
                stack_ptr = sp + 1;
            end
            tdse_pkg::F_FINDMARK: begin
                b = sp;
                while (b > 0 && stack_kind[b-1] != tdse_pkg::KIND_MARK) b--;
                if (b == 0) return tdse_pkg::ST_RANGE;
                c = sp - b;
                for (int i = b - 1; i + 1 < sp; i++) copy_el(i, i + 1);
                set_el(m, tdse_pkg::KIND_INT, tdse_pkg::VAL_W'(c));
            end
            default: ;
        endcase
        return tdse_pkg::ST_OK;
    endfunction

    function automatic tdse_pkg::t_result predict_result(input tdse_pkg::t_item it);
        tdse_pkg::t_result r;
        r.status = exec_word(it.func, it.push_kind, it.push_value);
        if (stack_ptr > 0) begin
            r.top_kind  = stack_kind[stack_ptr-1];
            r.top_value = stack_val[stack_ptr-1];
        end else begin
            r.top_kind  = '0;
            r.top_value = '0;
        end
        r.stack_count = tdse_pkg::SP_W'(stack_ptr);
        return r;
    endfunction

    always @(posedge i_clk) begin
        tdse_pkg::t_result want;
        if (i_rst_n) begin
            if (start && !busy) begin
                want = predict_result(i_item);
                expected_results.push_back(want);
                beats_in++;
                if (want.status != tdse_pkg::ST_OK) fault_beats++;
            end
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    report("result beat with nothing expected", 64'(o_result.status), 64'(0));
                end else begin
                    want = expected_results.pop_front();
                    beats_out++;
                    if (o_result.status != want.status)
                        report("status", 64'(o_result.status), 64'(want.status));
                    if (o_result.top_kind != want.top_kind)
                        report("top_kind", 64'(o_result.top_kind), 64'(want.top_kind));
                    if (o_result.top_value != want.top_value)
                        report("top_value", o_result.top_value, want.top_value);
                    if (o_result.stack_count != want.stack_count)
                        report("stack_count", 64'(o_result.stack_count),
                               64'(want.stack_count));
                end
            end
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    tdse_pkg::t_item   i_item;
    logic              o_done;
    tdse_pkg::t_result o_result;

    int errors;
    int pending;
    int beats_in;
    int beats_out;
    int fault_beats;
    int sent;
    int idle_pct;
    int quiet;
    int depth_seen;

    typed_data_stack_engine uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    tdse_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .errors      (errors),
        .pending     (pending),
        .beats_in    (beats_in),
        .beats_out   (beats_out),
        .fault_beats (fault_beats)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (o_done) depth_seen <= int'(o_result.stack_count);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send(input logic [4:0] f, input logic [3:0] k, input logic [63:0] v);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{func: f, push_kind: k, push_value: v};
        do @(posedge i_clk); while (busy);
        sent++;
        idle_pct = sent < 350 ? 17 : (sent < 700 ? 64 : 0);
    endtask

    task automatic push_int(input longint n);
        send(tdse_pkg::F_PUSH, tdse_pkg::KIND_INT, 64'(n));
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic counted_word();
        int          d;
        longint      n;
        logic [4:0]  f;
        d = depth_seen;
        case ($urandom_range(8))
            0: f = tdse_pkg::F_NDUP;
            1: f = tdse_pkg::F_DUPN;
            2: f = tdse_pkg::F_LDUP;
            3: f = tdse_pkg::F_PICK;
            4: f = tdse_pkg::F_PUT;
            5: f = tdse_pkg::F_POPN;
            6: f = tdse_pkg::F_ROTATE;
            7: f = tdse_pkg::F_REVERSE;
            default: f = tdse_pkg::F_LREVERSE;
        endcase
        case ($urandom_range(19))
            0: n = -longint'($urandom_range(1, 4));
            1: n = $signed(rand64());
            2: n = d + $urandom_range(0, 3);
            3: n = $urandom_range(0, d + 1);
            default: n = $urandom_range(0, d < 8 ? d + 1 : 8);
        endcase
        if (f == tdse_pkg::F_ROTATE && $urandom_range(1)) n = -n;
        if (d > 80 && (f == tdse_pkg::F_NDUP || f == tdse_pkg::F_DUPN ||
                       f == tdse_pkg::F_LDUP)) f = tdse_pkg::F_POPN;
        if ($urandom_range(15) == 0) send(tdse_pkg::F_PUSH, 4'($urandom_range(1, 15)), 64'(n));
        else push_int(n);
        send(f, 4'($urandom_range(15)), rand64());
    endtask

    initial begin
        logic [63:0] v;
        logic [3:0]  k;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        sent       = 0;
        idle_pct   = 17;
        quiet      = 0;
        depth_seen = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty stack faults and an unknown word
        send(tdse_pkg::F_POP, 4'd0, '0);
        send(tdse_pkg::F_FINDMARK, 4'd0, '0);
        send(tdse_pkg::F_NDUP, 4'd0, '0);
        send(tdse_pkg::F_ROT, 4'd0, '0);
        send(5'd25, 4'd9, '1);
        // field extremes and ordinary words
        send(tdse_pkg::F_PUSH, 4'd15, 64'h7fff_ffff_ffff_ffff);
        send(tdse_pkg::F_PUSH, tdse_pkg::KIND_MARK, 64'h8000_0000_0000_0000);
        send(tdse_pkg::F_PUSH, tdse_pkg::KIND_INT, '0);
        send(tdse_pkg::F_QDUP, 4'd0, '0);
        send(tdse_pkg::F_PUSH, 4'd7, 64'h0123_4567_89ab_cdef);
        send(tdse_pkg::F_QDUP, 4'd0, '0);
        send(tdse_pkg::F_DEPTH, 4'd0, '0);
        send(tdse_pkg::F_MARK, 4'd0, '0);
        send(tdse_pkg::F_DUP, 4'd0, '0);
        send(tdse_pkg::F_FINDMARK, 4'd0, '0);
        send(tdse_pkg::F_TUCK, 4'd0, '0);
        send(tdse_pkg::F_SWAP, 4'd0, '0);
        send(tdse_pkg::F_OVER, 4'd0, '0);
        send(tdse_pkg::F_NIP, 4'd0, '0);
        send(tdse_pkg::F_ROT, 4'd0, '0);
        // non-integer count, zero pick, negative ndup, zero and negative rotate
        send(tdse_pkg::F_PUSH, 4'd5, 64'd1);
        send(tdse_pkg::F_PICK, 4'd0, '0);
        push_int(0);
        send(tdse_pkg::F_PICK, 4'd0, '0);
        push_int(-1);
        send(tdse_pkg::F_NDUP, 4'd0, '0);
        push_int(0);
        send(tdse_pkg::F_ROTATE, 4'd0, '0);
        push_int(-3);
        send(tdse_pkg::F_ROTATE, 4'd0, '0);

        // fill to the top, then overflow and over-range popn
        settle();
        push_int(tdse_pkg::STACK_DEPTH - depth_seen);
        send(tdse_pkg::F_NDUP, 4'd0, '0);
        send(tdse_pkg::F_PUSH, 4'd3, '1);
        send(tdse_pkg::F_DEPTH, 4'd0, '0);
        send(tdse_pkg::F_POP, 4'd0, '0);
        push_int(tdse_pkg::STACK_DEPTH);
        send(tdse_pkg::F_POPN, 4'd0, '0);
        send(tdse_pkg::F_POP, 4'd0, '0);
        push_int(tdse_pkg::STACK_DEPTH - 10);
        send(tdse_pkg::F_POPN, 4'd0, '0);
        settle();

        while (sent < 1080) begin
            case ($urandom_range(19))
                0, 1, 2: begin
                    v = $urandom_range(3) == 0 ? 64'(0) : rand64();
                    send(5'($urandom_range(31)), 4'($urandom_range(15)), v);
                end
                3, 4, 5, 6, 7: begin
                    k = $urandom_range(3) == 0 ? 4'($urandom_range(15)) : tdse_pkg::KIND_INT;
                    case ($urandom_range(3))
                        0: v = '0;
                        1: v = 64'($urandom_range(20));
                        default: v = rand64();
                    endcase
                    if (depth_seen > 100) send(tdse_pkg::F_POP, k, v);
                    else send(tdse_pkg::F_PUSH, k, v);
                end
                8, 9, 10, 11, 12, 13, 14: counted_word();
                default: begin
                    case ($urandom_range(11))
                        0: send(tdse_pkg::F_POP, '0, '0);
                        1: send(tdse_pkg::F_DUP, '0, '0);
                        2: send(tdse_pkg::F_QDUP, '0, '0);
                        3: send(tdse_pkg::F_NIP, '0, '0);
                        4: send(tdse_pkg::F_TUCK, '0, '0);
                        5: send(tdse_pkg::F_SWAP, '0, '0);
                        6: send(tdse_pkg::F_OVER, '0, '0);
                        7: send(tdse_pkg::F_ROT, '0, '0);
                        8: send(tdse_pkg::F_DEPTH, '0, '0);
                        9: send(tdse_pkg::F_MARK, '0, '0);
                        default: send(tdse_pkg::F_FINDMARK, '0, '0);
                    endcase
                end
            endcase
        end

        settle();
        repeat (50) @(posedge i_clk);
        $display("tb: %0d words accepted, %0d results checked", beats_in, beats_out);
        $display("tb: %0d words ended in a fault status", fault_beats);
        if (errors == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/tdse_pkg.sv
design/tdse_dpath.sv
design/tdse_ctrl.sv
design/typed_data_stack_engine.sv
dv/tdse_checker.sv
dv/tb.sv
